// ===== rtl/hkvs_pkg.sv =====
package hkvs_pkg;

    // Fixed field widths
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int S_TDATA_W = 64;   // key, value
    localparam int M_TDATA_W = 40;   // status, result_value, zero pad
    localparam int STEP_W    = 2;    // step counter of the remainder unit

    // Request kind carried on tuser
    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_op;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    // Controller to datapath
    typedef struct packed {
        logic clear;      // write an empty row during the clearing pass
        logic accept;     // request taken this cycle
        logic lookup_rd;  // read the bucket row
        logic eval;       // row is registered, resolve the request
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last; // clearing pass is at the last bucket
        logic hash_done;  // bucket index is ready
        logic out_free;   // output register can take a result this cycle
    } t_stat;

endpackage

// ===== rtl/hkvs_bucket.sv =====
module hkvs_bucket #(
    parameter int NUM_BUCKETS = 2048
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [hkvs_pkg::KEY_W-1:0]         i_key,
    output logic                               o_done,
    output logic [$clog2(NUM_BUCKETS)-1:0]     o_bucket
);
    import hkvs_pkg::*;

    localparam int BW = $clog2(NUM_BUCKETS);
    localparam bit IS_POW2 = ((64'd1 << BW) == 64'(NUM_BUCKETS));
    // 2^32 mod NUM_BUCKETS, used to correct negative keys
    localparam longint unsigned WRAP_MOD = 64'd4294967296 % 64'(NUM_BUCKETS);
    localparam logic [BW:0] N_EXT = (BW+1)'(NUM_BUCKETS);
    localparam logic [BW:0] C_EXT = (BW+1)'(WRAP_MOD);

    if (IS_POW2) begin : g_mask
        logic [BW-1:0] r_bucket;

        // Floor modulo by a power of two is the low key bits
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_bucket <= '0;
            end else if (i_start) begin
                r_bucket <= i_key[BW-1:0];
            end
        end

        assign o_done   = 1'b1;
        assign o_bucket = r_bucket;
    end else begin : g_recip
        // floor(2^32 / NUM_BUCKETS): the quotient estimate is low by at most one
        localparam logic [KEY_W-1:0]  RECIP    = KEY_W'(64'd4294967296 / 64'(NUM_BUCKETS));
        localparam logic [KEY_W-1:0]  N_KEY    = KEY_W'(NUM_BUCKETS);
        localparam logic [STEP_W-1:0] STEP_MUL = STEP_W'(0);
        localparam logic [STEP_W-1:0] STEP_SUB = STEP_W'(1);
        localparam logic [STEP_W-1:0] STEP_FIX = STEP_W'(2);

        logic                r_busy;
        logic [STEP_W-1:0]   r_step;
        logic [KEY_W-1:0]    r_key;
        logic                r_neg;
        logic [KEY_W-1:0]    r_quot;
        logic [BW:0]         r_diff;
        logic [BW-1:0]       r_rem;
        logic [2*KEY_W-1:0]  product;
        logic [KEY_W-1:0]    back;
        logic [BW-1:0]       rem_pos;
        logic [BW:0]         rem_ext;
        logic [BW-1:0]       n_rem;

        // Quotient estimate, remainder below 2N, then one subtract and the sign fix
        always_comb begin
            product = (2*KEY_W)'(r_key) * (2*KEY_W)'(RECIP);
            back    = r_quot * N_KEY;
            if (r_diff >= N_EXT) begin
                rem_pos = BW'(r_diff - N_EXT);
            end else begin
                rem_pos = BW'(r_diff);
            end
            rem_ext = {1'b0, rem_pos};
            if (!r_neg) begin
                n_rem = rem_pos;
            end else if (rem_ext >= C_EXT) begin
                n_rem = BW'(rem_ext - C_EXT);
            end else begin
                n_rem = BW'(rem_ext + N_EXT - C_EXT);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy <= 1'b0;
                r_step <= '0;
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == STEP_FIX) begin
                    r_busy <= 1'b0;
                end
                r_step <= r_step + 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_key <= i_key;
                r_neg <= i_key[KEY_W-1];
            end else if (r_busy) begin
                case (r_step)
                    STEP_MUL: begin
                        r_quot <= product[2*KEY_W-1:KEY_W];
                    end
                    STEP_SUB: begin
                        r_diff <= (BW+1)'(r_key - back);
                    end
                    STEP_FIX: begin
                        r_rem <= n_rem;
                    end
                    default: begin
                    end
                endcase
            end
        end

        assign o_done   = !r_busy;
        assign o_bucket = r_rem;
    end

endmodule

// ===== rtl/hkvs_dp.sv =====
module hkvs_dp #(
    parameter int NUM_BUCKETS     = 2048,
    parameter int WAYS_PER_BUCKET = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hkvs_pkg::t_cmd                    i_cmd,
    output hkvs_pkg::t_stat                   o_stat,
    input  logic [hkvs_pkg::S_TDATA_W-1:0]    i_s_tdata,
    input  logic [0:0]                        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [hkvs_pkg::M_TDATA_W-1:0]    o_m_tdata
);
    import hkvs_pkg::*;

    localparam int BW     = $clog2(NUM_BUCKETS);
    localparam int CW     = $clog2(WAYS_PER_BUCKET + 1);
    localparam int WAY_W  = KEY_W + VAL_W;
    localparam int ROW_W  = CW + WAYS_PER_BUCKET * WAY_W;
    localparam int PAD_W  = M_TDATA_W - STAT_W - VAL_W;

    // Request registers
    t_op              r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;

    // Bucket memory: fill count in the low bits, then the ways
    logic [ROW_W-1:0] r_mem [NUM_BUCKETS];
    logic [ROW_W-1:0] r_row;
    logic [BW-1:0]    r_clr_addr;

    logic [BW-1:0]    bucket;
    logic             hash_done;
    logic             out_free;
    logic             eval_go;

    logic [CW-1:0]    row_count;
    logic             full;
    logic             hit_found;
    logic [VAL_W-1:0] hit_value;
    logic [ROW_W-1:0] new_row;
    logic [STAT_W-1:0] n_status;
    logic [VAL_W-1:0] n_result;

    logic             mem_we;
    logic [BW-1:0]    mem_waddr;
    logic [ROW_W-1:0] mem_wdata;

    logic             r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;

    hkvs_bucket #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_bucket (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.accept),
        .i_key    (i_s_tdata[KEY_W-1:0]),
        .o_done   (hash_done),
        .o_bucket (bucket)
    );

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= t_op'(i_s_tuser[0]);
            r_key   <= i_s_tdata[KEY_W-1:0];
            r_value <= i_s_tdata[S_TDATA_W-1:KEY_W];
        end
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Resolve the request against the registered row
    always_comb begin
        row_count = r_row[CW-1:0];
        full      = (row_count == CW'(WAYS_PER_BUCKET));
        hit_found = 1'b0;
        hit_value = MISS_VALUE;
        new_row   = r_row;
        // Walk down so the lowest matching way wins
        for (int w = WAYS_PER_BUCKET - 1; w >= 0; w--) begin
            if ((CW'(w) < row_count) && (r_row[CW + w*WAY_W +: KEY_W] == r_key)) begin
                hit_found = 1'b1;
                hit_value = r_row[CW + w*WAY_W + KEY_W +: VAL_W];
            end
        end
        new_row[CW-1:0] = row_count + 1'b1;
        for (int w = 0; w < WAYS_PER_BUCKET; w++) begin
            if (CW'(w) == row_count) begin
                new_row[CW + w*WAY_W +: KEY_W]         = r_key;
                new_row[CW + w*WAY_W + KEY_W +: VAL_W] = r_value;
            end
        end
        if (r_op == CMD_LOOKUP) begin
            n_status = hit_found ? ST_OK : ST_MISS;
            n_result = hit_value;
        end else begin
            n_status = full ? ST_FULL : ST_OK;
            n_result = '0;
        end
    end

    assign out_free = !r_m_tvalid || i_m_tready;
    assign eval_go  = i_cmd.eval && out_free;

    // Memory write: empty rows during clear, updated row on an insert into a bucket that is not full
    assign mem_we    = i_cmd.clear || (eval_go && (r_op == CMD_INSERT) && !full);
    assign mem_waddr = i_cmd.clear ? r_clr_addr : bucket;
    assign mem_wdata = i_cmd.clear ? '0 : new_row;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup_rd) begin
            r_row <= r_mem[bucket];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (eval_go) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_go) begin
            r_m_tdata <= {{PAD_W{1'b0}}, n_result, n_status};
        end
    end

    assign o_m_tvalid        = r_m_tvalid;
    assign o_m_tdata         = r_m_tdata;
    assign o_stat.clear_last = (r_clr_addr == BW'(NUM_BUCKETS - 1));
    assign o_stat.hash_done  = hash_done;
    assign o_stat.out_free   = out_free;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |-> (row_count <= CW'(WAYS_PER_BUCKET)))
        else $error("bucket fill count beyond way count");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        eval_go |=> r_m_tvalid)
        else $error("resolved request produced no result");

    a_read_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lookup_rd |-> hash_done)
        else $error("row read before bucket index ready");

    a_clear_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |-> !(i_cmd.accept || i_cmd.eval))
        else $error("request handled during clearing pass");
`endif

endmodule

// ===== rtl/hkvs_ctrl.sv =====
module hkvs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  hkvs_pkg::t_stat   i_stat,
    output hkvs_pkg::t_cmd    o_cmd
);
    import hkvs_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_EVAL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // Ready while idle, or while a result is resolved into a free output register
    assign o_s_tready = (r_state == S_IDLE) || ((r_state == S_EVAL) && i_stat.out_free);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_cmd.clear     = (r_state == S_CLEAR);
        o_cmd.accept    = accept;
        o_cmd.lookup_rd = (r_state == S_HASH) && i_stat.hash_done;
        o_cmd.eval      = (r_state == S_EVAL);
        n_state         = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.hash_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (accept) begin
                    n_state = S_HASH;
                end else if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_ready_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_s_tready)
        else $error("ready during clearing pass");

    a_accept_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_HASH))
        else $error("accepted request not hashed");

    a_eval_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EVAL) && !i_stat.out_free) |=> (r_state == S_EVAL))
        else $error("result dropped while output stalled");
`endif

endmodule

// ===== rtl/hashed_key_value_store.sv =====
// Channel   Dir  Signals                          Contents
// s         in   i_s_tvalid/o_s_tready            tdata: key, value; tuser: cmd
// m         out  o_m_tvalid/i_m_tready            tdata: status, result_value
//
// When NUM_BUCKETS is a power of two the bucket index is registered from the low key bits; else
// the bucket remainder takes three steps (reciprocal multiply, multiply back
// and subtract, final subtract with sign correction).
// Then the bucket row is read synchronously and the request is compared and, for an insert, written back.
// After reset a clearing pass empties every bucket; no request is taken meanwhile.
// A stalled result holds in the output register while the next request is taken
// and hashed; that request waits to resolve until the register frees.
module hashed_key_value_store #(
    parameter int NUM_BUCKETS     = 2048,
    parameter int WAYS_PER_BUCKET = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [hkvs_pkg::S_TDATA_W-1:0]   i_s_tdata,  // [31:0] key, [63:32] value
    input  logic [0:0]                       i_s_tuser,  // [0] cmd
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [hkvs_pkg::M_TDATA_W-1:0]   o_m_tdata   // [1:0] status, [33:2] result_value
);
    import hkvs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    hkvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hkvs_dp #(
        .NUM_BUCKETS     (NUM_BUCKETS),
        .WAYS_PER_BUCKET (WAYS_PER_BUCKET)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
